### hw/rtl/assert_macros.svh
// Assertion macros for the queue RTL; only the control block includes them.
// They expand to concurrent assertions in simulation and to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TLPQ_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tlpq assertion failed");
`define TLPQ_ASSERT_NR(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("tlpq assertion failed");
`else
`define TLPQ_ASSERT(name, clk, rst_n, prop)
`define TLPQ_ASSERT_NR(name, clk, prop)
`endif
`endif

### hw/rtl/tlpq_pkg.sv
package tlpq_pkg;

    localparam int OPCODE_W = 3;
    localparam int WORD_W   = 32;
    localparam int LEVEL_W  = 2;
    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 9;
    localparam int TOTAL_W  = 10;
    localparam int STATUS_W = 3;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_PEEK  = 3'd2,
        OP_READ  = 3'd3,
        OP_CLEAR = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_BAD_LEVEL = 3'd2,
        ST_BAD_INDEX = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    localparam logic [LEVEL_W-1:0] LVL_NONE = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_ONE  = 2'd1;

    // Result of one command, minus the data word that arrives from the store.
    typedef struct packed {
        logic                 has_data;
        logic [LEVEL_W-1:0]   level;
        status_t              status;
        logic [COUNT_W-1:0]   count_high;
        logic [COUNT_W-1:0]   count_medium;
        logic [COUNT_W-1:0]   count_low;
        logic [TOTAL_W-1:0]   count_total;
    } result_info_t;

endpackage

### hw/rtl/three_level_priority_fifo.sv
// Three-level strict priority queue with a stream command port and a stream
// result port. Each command item (push, pop front, peek front, read at an
// overall position, clear) returns exactly one result item carrying the data
// word and level of the returned entry, a status code and the per-level and
// total counts after the command. Levels 1 (high), 2 (medium) and 3 (low) each
// keep first-in first-out order in their own ring of LEVEL_DEPTH words, and
// overall positions run through all high entries, then medium, then low. All
// words sit in one synchronous single-port memory that is touched at most once
// per command; the ring pointers and counts live in small registers and are
// updated in the cycle the command is accepted. The block sustains one command
// per clock cycle while m_tready stays high; each result passes first through
// the pending register, beside the registered memory read, then the output
// register. A command is still taken while an earlier result waits there for
// the downstream ready, if the pending register is free. Entries that were
// never written are never read, so the memory needs no clearing after reset.
module three_level_priority_fifo #(
    parameter int DATA_WIDTH  = 32,
    parameter int LEVEL_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, low bit up: data_in[31:0], priority_level[33:32],
    // item_index[43:34], zero pad[47:44].
    input  logic [47:0] s_tdata,
    // s_tuser: opcode[2:0].
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, low bit up: result_data[31:0], result_level[33:32],
    // count_high[42:34], count_medium[51:43], count_low[60:52],
    // count_total[70:61], zero pad[71].
    output logic [71:0] m_tdata,
    // m_tuser: status[2:0].
    output logic [2:0]  m_tuser
);

    localparam int PW = $clog2(LEVEL_DEPTH);

    logic                   pend_take;
    logic                   pend_valid;
    tlpq_pkg::result_info_t pend_info;
    logic                   mem_we;
    logic                   mem_re;
    logic [PW+1:0]          mem_addr;
    logic [DATA_WIDTH-1:0]  mem_wdata;
    logic [DATA_WIDTH-1:0]  rd_data;

    // Command queue control: ring pointers, counts and memory addressing.
    tlpq_ctrl #(
        .DATA_WIDTH  (DATA_WIDTH),
        .LEVEL_DEPTH (LEVEL_DEPTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .op             (tlpq_pkg::op_t'(s_tuser)),
        .data_in        (s_tdata[31:0]),
        .priority_level (s_tdata[33:32]),
        .item_index     (s_tdata[43:34]),
        .pend_take      (pend_take),
        .pend_valid     (pend_valid),
        .pend_info      (pend_info),
        .mem_we         (mem_we),
        .mem_re         (mem_re),
        .mem_addr       (mem_addr),
        .mem_wdata      (mem_wdata)
    );

    // Word storage for all three rings.
    tlpq_store #(
        .DATA_WIDTH (DATA_WIDTH),
        .PTR_W      (PW)
    ) u_store (
        .clk     (clk),
        .we      (mem_we),
        .re      (mem_re),
        .addr    (mem_addr),
        .wdata   (mem_wdata),
        .rd_data (rd_data)
    );

    // Result register that joins the read word with the command's status.
    tlpq_outreg #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_outreg (
        .clk        (clk),
        .rst_n      (rst_n),
        .pend_valid (pend_valid),
        .pend_info  (pend_info),
        .rd_data    (rd_data),
        .pend_take  (pend_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

### hw/rtl/tlpq_store.sv
module tlpq_store #(
    parameter int DATA_WIDTH = 32,
    parameter int PTR_W      = 8
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic                  re,
    input  logic [PTR_W+1:0]      addr,
    input  logic [DATA_WIDTH-1:0] wdata,
    output logic [DATA_WIDTH-1:0] rd_data
);

    // Three rings side by side; the level selects the upper address bits.
    localparam int ENTRIES = 3 * (2 ** PTR_W);

    logic [DATA_WIDTH-1:0] mem [0:ENTRIES-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rd_data <= mem[addr];
        end
    end

endmodule

### hw/rtl/tlpq_outreg.sv
module tlpq_outreg #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pend_valid,
    input  tlpq_pkg::result_info_t pend_info,
    input  logic [DATA_WIDTH-1:0]  rd_data,
    output logic                   pend_take,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [71:0]            m_tdata,
    output logic [2:0]             m_tuser
);

    logic                               out_valid_reg;
    logic                               out_valid_next;
    tlpq_pkg::result_info_t             out_info_reg;
    logic [tlpq_pkg::WORD_W-1:0]        out_data_reg;
    logic [DATA_WIDTH+tlpq_pkg::WORD_W-1:0] rd_ext;

    assign rd_ext    = {{tlpq_pkg::WORD_W{1'b0}}, rd_data};
    assign pend_take = pend_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        if (pend_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_take)
        begin
            out_info_reg <= pend_info;
            out_data_reg <= pend_info.has_data ? rd_ext[tlpq_pkg::WORD_W-1:0]
                                               : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_info_reg.status;
    assign m_tdata  = {1'b0,
                       out_info_reg.count_total,
                       out_info_reg.count_low,
                       out_info_reg.count_medium,
                       out_info_reg.count_high,
                       out_info_reg.level,
                       out_data_reg};

endmodule

### hw/rtl/tlpq_ctrl.sv
`include "assert_macros.svh"

module tlpq_ctrl #(
    parameter int DATA_WIDTH  = 32,
    parameter int LEVEL_DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  tlpq_pkg::op_t                          op,
    input  logic [tlpq_pkg::WORD_W-1:0]            data_in,
    input  logic [tlpq_pkg::LEVEL_W-1:0]           priority_level,
    input  logic [tlpq_pkg::INDEX_W-1:0]           item_index,
    input  logic                                   pend_take,
    output logic                                   pend_valid,
    output tlpq_pkg::result_info_t                 pend_info,
    output logic                                   mem_we,
    output logic                                   mem_re,
    output logic [$clog2(LEVEL_DEPTH)+1:0]         mem_addr,
    output logic [DATA_WIDTH-1:0]                  mem_wdata
);

    localparam int CW = $clog2(LEVEL_DEPTH + 1);
    localparam int PW = $clog2(LEVEL_DEPTH);
    localparam int SW = CW + 2;
    localparam int TW = (SW > tlpq_pkg::INDEX_W) ? SW : tlpq_pkg::INDEX_W;

    logic [CW-1:0] cnt_reg  [3];
    logic [CW-1:0] cnt_next [3];
    logic [PW-1:0] head_reg [3];
    logic [PW-1:0] head_next[3];

    logic                   pend_valid_reg;
    logic                   pend_valid_next;
    tlpq_pkg::result_info_t pend_info_reg;
    tlpq_pkg::result_info_t info_c;

    logic          accept;
    logic [TW-1:0] c0_ext;
    logic [TW-1:0] c1_ext;
    logic [TW-1:0] c2_ext;
    logic [TW-1:0] sum01;
    logic [TW-1:0] total;
    logic [TW-1:0] idx_ext;
    logic          empty;
    logic [1:0]    front_lvl;
    logic [1:0]    walk_lvl;
    logic [TW-1:0] walk_off;
    logic [1:0]    lvl_sel;
    logic [CW-1:0] sel_cnt;
    logic [PW-1:0] sel_head;
    logic [PW-1:0] head_inc;
    logic [PW-1:0] off;
    logic [PW:0]   ring_sum;
    logic [PW-1:0] ring_pos;
    logic          full;
    logic          we_c;
    logic          re_c;
    logic          counts_ok;
    logic [SW-1:0] total_next;
    logic [CW+tlpq_pkg::COUNT_W-1:0] cext0;
    logic [CW+tlpq_pkg::COUNT_W-1:0] cext1;
    logic [CW+tlpq_pkg::COUNT_W-1:0] cext2;
    logic [SW+tlpq_pkg::TOTAL_W-1:0] text;
    logic [DATA_WIDTH+tlpq_pkg::WORD_W-1:0] wd_ext;

    assign accept   = in_valid && in_ready;
    assign in_ready = !pend_valid_reg || pend_take;

    // Overall position order runs high, then medium, then low.
    assign c0_ext  = TW'(cnt_reg[0]);
    assign c1_ext  = TW'(cnt_reg[1]);
    assign c2_ext  = TW'(cnt_reg[2]);
    assign sum01   = c0_ext + c1_ext;
    assign total   = sum01 + c2_ext;
    assign idx_ext = TW'(item_index);
    assign empty   = (total == '0);

    always_comb
    begin
        priority if (cnt_reg[0] != '0)
        begin
            front_lvl = 2'd0;
        end
        else if (cnt_reg[1] != '0)
        begin
            front_lvl = 2'd1;
        end
        else
        begin
            front_lvl = 2'd2;
        end
    end

    always_comb
    begin
        priority if (idx_ext < c0_ext)
        begin
            walk_lvl = 2'd0;
            walk_off = idx_ext;
        end
        else if (idx_ext < sum01)
        begin
            walk_lvl = 2'd1;
            walk_off = idx_ext - c0_ext;
        end
        else
        begin
            walk_lvl = 2'd2;
            walk_off = idx_ext - sum01;
        end
    end

    always_comb
    begin
        unique case (op)
            tlpq_pkg::OP_PUSH: lvl_sel = priority_level - tlpq_pkg::LVL_ONE;
            tlpq_pkg::OP_READ: lvl_sel = walk_lvl;
            default:           lvl_sel = front_lvl;
        endcase
    end

    always_comb
    begin
        unique case (lvl_sel)
            2'd0:
            begin
                sel_cnt  = cnt_reg[0];
                sel_head = head_reg[0];
            end
            2'd1:
            begin
                sel_cnt  = cnt_reg[1];
                sel_head = head_reg[1];
            end
            2'd2:
            begin
                sel_cnt  = cnt_reg[2];
                sel_head = head_reg[2];
            end
            default:
            begin
                sel_cnt  = '0;
                sel_head = '0;
            end
        endcase
    end

    always_comb
    begin
        unique case (op)
            tlpq_pkg::OP_PUSH: off = sel_cnt[PW-1:0];
            tlpq_pkg::OP_READ: off = walk_off[PW-1:0];
            default:           off = '0;
        endcase
    end

    // Ring position: head plus offset, wrapped once at the level depth.
    assign ring_sum = {1'b0, sel_head} + {1'b0, off};
    assign ring_pos = (ring_sum >= (PW+1)'(LEVEL_DEPTH))
                    ? PW'(ring_sum - (PW+1)'(LEVEL_DEPTH))
                    : ring_sum[PW-1:0];
    assign head_inc = (sel_head == PW'(LEVEL_DEPTH - 1)) ? '0 : sel_head + 1'b1;
    assign full     = (sel_cnt == CW'(LEVEL_DEPTH));

    always_comb
    begin
        we_c           = 1'b0;
        re_c           = 1'b0;
        info_c         = '0;
        info_c.status  = tlpq_pkg::ST_OK;
        cnt_next[0]    = cnt_reg[0];
        cnt_next[1]    = cnt_reg[1];
        cnt_next[2]    = cnt_reg[2];
        head_next[0]   = head_reg[0];
        head_next[1]   = head_reg[1];
        head_next[2]   = head_reg[2];
        unique case (op)
            tlpq_pkg::OP_PUSH:
            begin
                priority if (priority_level == tlpq_pkg::LVL_NONE)
                begin
                    info_c.status = tlpq_pkg::ST_BAD_LEVEL;
                end
                else if (full)
                begin
                    info_c.status = tlpq_pkg::ST_FULL;
                end
                else
                begin
                    we_c              = 1'b1;
                    cnt_next[lvl_sel] = sel_cnt + 1'b1;
                end
            end
            tlpq_pkg::OP_POP, tlpq_pkg::OP_PEEK:
            begin
                if (empty)
                begin
                    info_c.status = tlpq_pkg::ST_EMPTY;
                end
                else
                begin
                    re_c            = 1'b1;
                    info_c.has_data = 1'b1;
                    info_c.level    = lvl_sel + tlpq_pkg::LVL_ONE;
                    if (op == tlpq_pkg::OP_POP)
                    begin
                        head_next[lvl_sel] = head_inc;
                        cnt_next[lvl_sel]  = sel_cnt - 1'b1;
                    end
                end
            end
            tlpq_pkg::OP_READ:
            begin
                if (idx_ext >= total)
                begin
                    info_c.status = tlpq_pkg::ST_BAD_INDEX;
                end
                else
                begin
                    re_c            = 1'b1;
                    info_c.has_data = 1'b1;
                    info_c.level    = lvl_sel + tlpq_pkg::LVL_ONE;
                end
            end
            tlpq_pkg::OP_CLEAR:
            begin
                cnt_next[0]  = '0;
                cnt_next[1]  = '0;
                cnt_next[2]  = '0;
                head_next[0] = '0;
                head_next[1] = '0;
                head_next[2] = '0;
            end
            default:
            begin
            end
        endcase
        info_c.count_high   = cext0[tlpq_pkg::COUNT_W-1:0];
        info_c.count_medium = cext1[tlpq_pkg::COUNT_W-1:0];
        info_c.count_low    = cext2[tlpq_pkg::COUNT_W-1:0];
        info_c.count_total  = text[tlpq_pkg::TOTAL_W-1:0];
    end

    // Counts after the step, cut to the width of the result fields.
    assign total_next = SW'(cnt_next[0]) + SW'(cnt_next[1]) + SW'(cnt_next[2]);
    assign cext0      = {{tlpq_pkg::COUNT_W{1'b0}}, cnt_next[0]};
    assign cext1      = {{tlpq_pkg::COUNT_W{1'b0}}, cnt_next[1]};
    assign cext2      = {{tlpq_pkg::COUNT_W{1'b0}}, cnt_next[2]};
    assign text       = {{tlpq_pkg::TOTAL_W{1'b0}}, total_next};

    assign wd_ext    = {{DATA_WIDTH{1'b0}}, data_in};
    assign mem_wdata = wd_ext[DATA_WIDTH-1:0];
    assign mem_addr  = {lvl_sel, ring_pos};
    assign mem_we    = accept && we_c;
    assign mem_re    = accept && re_c;

    always_comb
    begin
        if (accept)
        begin
            pend_valid_next = 1'b1;
        end
        else if (pend_take)
        begin
            pend_valid_next = 1'b0;
        end
        else
        begin
            pend_valid_next = pend_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                cnt_reg[i]  <= '0;
                head_reg[i] <= '0;
            end
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            if (accept)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    cnt_reg[i]  <= cnt_next[i];
                    head_reg[i] <= head_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_info_reg <= info_c;
        end
    end

    assign pend_valid = pend_valid_reg;
    assign pend_info  = pend_info_reg;

    // No level ever holds more than its ring depth.
    assign counts_ok = (cnt_reg[0] <= CW'(LEVEL_DEPTH)) && (cnt_reg[1] <= CW'(LEVEL_DEPTH))
                    && (cnt_reg[2] <= CW'(LEVEL_DEPTH));

    `TLPQ_ASSERT(a_single_access, clk, rst_n, !(mem_we && mem_re))
    `TLPQ_ASSERT(a_count_bound, clk, rst_n, counts_ok)
    `TLPQ_ASSERT(a_clear_empties, clk, rst_n, (accept && op == tlpq_pkg::OP_CLEAR) |=> empty)
    `TLPQ_ASSERT(a_pend_holds, clk, rst_n, (pend_valid_reg && !pend_take) |=> pend_valid_reg)

endmodule
